// ===== sv/cei_pkg.sv =====
// Shared types and constants for the clip edge intersection block.
package cei_pkg;

    localparam int QDEPTH = 2;
    localparam int QPW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = 68;
    localparam int NATTR = 7;

    localparam logic [1:0] SIDE_TOP    = 2'd0;
    localparam logic [1:0] SIDE_BOTTOM = 2'd1;
    localparam logic [1:0] SIDE_LEFT   = 2'd2;
    localparam logic [1:0] SIDE_RIGHT  = 2'd3;

    localparam logic [2:0] CFG_EDGE_START_X = 3'd0;
    localparam logic [2:0] CFG_EDGE_START_Y = 3'd1;
    localparam logic [2:0] CFG_EDGE_END_X   = 3'd2;
    localparam logic [2:0] CFG_EDGE_END_Y   = 3'd3;
    localparam logic [2:0] CFG_CLIP_SIDE    = 3'd4;

    typedef struct packed {
        logic [31:0] esx;
        logic [31:0] esy;
        logic [31:0] eex;
        logic [31:0] eey;
        logic [1:0]  side;
    } cei_cfg_t;

    typedef struct packed {
        logic [31:0] sx;
        logic [31:0] sy;
        logic [31:0] sz;
        logic [31:0] su;
        logic [31:0] sv;
        logic [7:0]  sr;
        logic [7:0]  sg;
        logic [7:0]  sb;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [31:0] vu;
        logic [31:0] vv;
        logic [7:0]  vr;
        logic [7:0]  vg;
        logic [7:0]  vb;
    } cei_seg_t;

endpackage

// ===== sv/clip_edge_intersect_interp.sv =====
// Top level of the clip edge intersection block: configuration registers and the two halves.
// A holding vertex is stored as the segment start. A closing vertex enters a two-entry segment
// queue, and the back end then takes it from the queue, forms differences and cross products
// through one shared 34x34 multiplier, checks for a crossing, runs one restoring divider step
// per bit of t, interpolates the attributes in a pipeline through the same multiplier and loads
// the result register. A segment that misses skips the divider and the interpolation. The result
// register holds until popped and the back end stalls behind it. The queue keeps vertices flowing
// while the back end works and the result waits to be popped.
module clip_edge_intersect_interp
    import cei_pkg::*;
#(
    parameter int T_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic [2:0]  wr_index,
    input  logic [31:0] wr_data,
    input  logic        push,
    output logic        full,
    input  logic        is_second,
    input  logic [31:0] vert_x,
    input  logic [31:0] vert_y,
    input  logic [31:0] vert_z,
    input  logic [31:0] vert_u,
    input  logic [31:0] vert_v,
    input  logic [7:0]  vert_red,
    input  logic [7:0]  vert_green,
    input  logic [7:0]  vert_blue,
    output logic        empty,
    input  logic        pop,
    output logic        hit,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [31:0] out_u,
    output logic [31:0] out_v,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);

    cei_cfg_t cfg_reg;
    cei_seg_t q_data;
    logic     q_valid, q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else if (wr_en)
        begin
            unique case (wr_index)
                CFG_EDGE_START_X: cfg_reg.esx <= wr_data;
                CFG_EDGE_START_Y: cfg_reg.esy <= wr_data;
                CFG_EDGE_END_X:   cfg_reg.eex <= wr_data;
                CFG_EDGE_END_Y:   cfg_reg.eey <= wr_data;
                CFG_CLIP_SIDE:    cfg_reg.side <= wr_data[1:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    cei_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .is_second  (is_second),
        .vert_x     (vert_x),
        .vert_y     (vert_y),
        .vert_z     (vert_z),
        .vert_u     (vert_u),
        .vert_v     (vert_v),
        .vert_red   (vert_red),
        .vert_green (vert_green),
        .vert_blue  (vert_blue),
        .q_data     (q_data),
        .q_valid    (q_valid),
        .q_pop      (q_pop)
    );

    cei_back #(
        .T_FRAC_BITS (T_FRAC_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_data    (q_data),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .empty     (empty),
        .pop       (pop),
        .hit       (hit),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_u     (out_u),
        .out_v     (out_v),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue)
    );

endmodule

// ===== sv/cei_front.sv =====
// Front end: holds the segment start and queues closed segments.
module cei_front
    import cei_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        is_second,
    input  logic [31:0] vert_x,
    input  logic [31:0] vert_y,
    input  logic [31:0] vert_z,
    input  logic [31:0] vert_u,
    input  logic [31:0] vert_v,
    input  logic [7:0]  vert_red,
    input  logic [7:0]  vert_green,
    input  logic [7:0]  vert_blue,
    output cei_seg_t    q_data,
    output logic        q_valid,
    input  logic        q_pop
);

    logic [31:0] sx_reg, sy_reg, sz_reg, su_reg, sv_reg;
    logic [7:0]  sr_reg, sg_reg, sb_reg;
    cei_seg_t    mem_reg [QDEPTH];
    logic [QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPW:0]   cnt_reg;
    logic accept, do_wr, do_rd;
    cei_seg_t wr_entry;

    assign full    = (cnt_reg == (QPW+1)'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_data  = mem_reg[rd_ptr_reg];
    assign accept  = push && !full;
    assign do_wr   = accept && is_second;
    assign do_rd   = q_pop && q_valid;

    always_comb
    begin
        wr_entry = '{sx: sx_reg, sy: sy_reg, sz: sz_reg, su: su_reg, sv: sv_reg,
                     sr: sr_reg, sg: sg_reg, sb: sb_reg,
                     vx: vert_x, vy: vert_y, vz: vert_z, vu: vert_u, vv: vert_v,
                     vr: vert_red, vg: vert_green, vb: vert_blue};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_reg <= '0; sy_reg <= '0; sz_reg <= '0; su_reg <= '0; sv_reg <= '0;
            sr_reg <= '0; sg_reg <= '0; sb_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (accept && !is_second)
            begin
                sx_reg <= vert_x; sy_reg <= vert_y; sz_reg <= vert_z;
                su_reg <= vert_u; sv_reg <= vert_v;
                sr_reg <= vert_red; sg_reg <= vert_green; sb_reg <= vert_blue;
            end
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == QPW'(QDEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == QPW'(QDEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (!do_wr && do_rd)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_entry;
    end

endmodule

// ===== sv/cei_back.sv =====
// Back end: cross products, t divider, attribute interpolation and result register.
module cei_back
    import cei_pkg::*;
#(
    parameter int T_FRAC_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cei_cfg_t    cfg,
    input  cei_seg_t    q_data,
    input  logic        q_valid,
    output logic        q_pop,
    output logic        empty,
    input  logic        pop,
    output logic        hit,
    output logic [31:0] out_x,
    output logic [31:0] out_y,
    output logic [31:0] out_z,
    output logic [31:0] out_u,
    output logic [31:0] out_v,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue
);

    localparam int CNTW = $clog2(((T_FRAC_BITS > 9) ? T_FRAC_BITS : 9) + 1);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CROSS = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_LERP  = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]       state_reg;
    logic [CNTW-1:0]  cnt_reg;
    cei_seg_t         seg_reg;
    logic signed [32:0] dvx_reg, dvy_reg, dex_reg, dey_reg, dxx_reg, dxy_reg;
    logic signed [CW-1:0] prod_reg, den_reg, num_reg;
    logic signed [CW-1:0] prod_next;
    logic signed [33:0] mul_a, mul_b;
    logic [CW-1:0]    rem_reg, ad_reg, an, ad;
    logic [CW:0]      rem2;
    logic             ge;
    logic [T_FRAC_BITS-1:0] tq_reg;
    logic [32:0]      dmag_reg;
    logic             dneg1_reg, dneg2_reg;
    logic [31:0]      abase1_reg, abase2_reg;
    logic [31:0]      res_reg [NATTR];
    logic             miss_reg;
    logic signed [32:0] attr_a, attr_b, attr_d;
    logic [2:0]       attr_idx, res_idx;
    logic [31:0]      step, lerp_val;
    logic             miss;
    logic             out_valid_reg, out_hit_reg;
    logic [31:0]      out_x_reg, out_y_reg, out_z_reg, out_u_reg, out_v_reg;
    logic [7:0]       out_red_reg, out_green_reg, out_blue_reg;
    logic             out_free;

    function automatic logic signed [32:0] sx33(input logic [31:0] a);
        sx33 = $signed({a[31], a});
    endfunction

    function automatic logic signed [32:0] zx33(input logic [7:0] a);
        zx33 = $signed({25'd0, a});
    endfunction

    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign out_free = !out_valid_reg || pop;
    assign empty    = !out_valid_reg;

    assign an = num_reg[CW-1] ? CW'(-num_reg) : CW'(num_reg);
    assign ad = den_reg[CW-1] ? CW'(-den_reg) : CW'(den_reg);
    assign miss = (den_reg == '0) || (num_reg == '0) ||
                  (den_reg[CW-1] != num_reg[CW-1]) || (an >= ad);

    assign rem2 = {rem_reg, 1'b0};
    assign ge   = (rem2 >= {1'b0, ad_reg});

    assign attr_idx = cnt_reg[2:0];
    assign res_idx  = 3'(cnt_reg - CNTW'(2));

    always_comb
    begin
        unique case (attr_idx)
            3'd0:
            begin
                attr_a = (cfg.side == SIDE_TOP || cfg.side == SIDE_BOTTOM) ?
                         sx33(seg_reg.sx) : sx33(seg_reg.sy);
                attr_b = (cfg.side == SIDE_TOP || cfg.side == SIDE_BOTTOM) ?
                         sx33(seg_reg.vx) : sx33(seg_reg.vy);
            end
            3'd1:    begin attr_a = sx33(seg_reg.sz); attr_b = sx33(seg_reg.vz); end
            3'd2:    begin attr_a = sx33(seg_reg.su); attr_b = sx33(seg_reg.vu); end
            3'd3:    begin attr_a = sx33(seg_reg.sv); attr_b = sx33(seg_reg.vv); end
            3'd4:    begin attr_a = zx33(seg_reg.sr); attr_b = zx33(seg_reg.vr); end
            3'd5:    begin attr_a = zx33(seg_reg.sg); attr_b = zx33(seg_reg.vg); end
            3'd6:    begin attr_a = zx33(seg_reg.sb); attr_b = zx33(seg_reg.vb); end
            default: begin attr_a = '0; attr_b = '0; end
        endcase
        attr_d = attr_b - attr_a;
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_CROSS)
        begin
            priority case (cnt_reg)
                CNTW'(1): begin mul_a = 34'(dvx_reg); mul_b = 34'(dxy_reg); end
                CNTW'(2): begin mul_a = 34'(dvy_reg); mul_b = 34'(dxx_reg); end
                CNTW'(3): begin mul_a = 34'(dex_reg); mul_b = 34'(dxy_reg); end
                CNTW'(4): begin mul_a = 34'(dey_reg); mul_b = 34'(dxx_reg); end
                default:  begin mul_a = '0; mul_b = '0; end
            endcase
        end
        else if (state_reg == ST_LERP)
        begin
            mul_a = $signed({1'b0, dmag_reg});
            mul_b = $signed(34'(tq_reg));
        end
        prod_next = mul_a * mul_b;
    end

    assign step     = prod_reg[T_FRAC_BITS+31:T_FRAC_BITS];
    assign lerp_val = dneg2_reg ? abase2_reg - step : abase2_reg + step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == ST_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (q_valid)
                    begin
                        state_reg <= ST_CROSS;
                        cnt_reg <= '0;
                    end
                ST_CROSS:
                    if (cnt_reg == CNTW'(5))
                        state_reg <= ST_CHECK;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                ST_CHECK:
                begin
                    cnt_reg <= '0;
                    state_reg <= miss ? ST_OUT : ST_DIV;
                end
                ST_DIV:
                    if (cnt_reg == CNTW'(T_FRAC_BITS-1))
                    begin
                        cnt_reg <= '0;
                        state_reg <= ST_LERP;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                ST_LERP:
                    if (cnt_reg == CNTW'(NATTR+1))
                        state_reg <= ST_OUT;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                ST_OUT:
                    if (out_free)
                        state_reg <= ST_IDLE;
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (q_pop)
            seg_reg <= q_data;
        if (state_reg == ST_CROSS)
        begin
            priority case (cnt_reg)
                CNTW'(0):
                begin
                    dvx_reg <= sx33(seg_reg.vx) - sx33(seg_reg.sx);
                    dvy_reg <= sx33(seg_reg.vy) - sx33(seg_reg.sy);
                    dex_reg <= sx33(cfg.esx) - sx33(seg_reg.sx);
                    dey_reg <= sx33(cfg.esy) - sx33(seg_reg.sy);
                    dxx_reg <= sx33(cfg.eex) - sx33(cfg.esx);
                    dxy_reg <= sx33(cfg.eey) - sx33(cfg.esy);
                end
                CNTW'(2): den_reg <= prod_reg;
                CNTW'(3): den_reg <= den_reg - prod_reg;
                CNTW'(4): num_reg <= prod_reg;
                CNTW'(5): num_reg <= num_reg - prod_reg;
                default:  den_reg <= den_reg;
            endcase
        end
        if (state_reg == ST_CHECK)
        begin
            miss_reg <= miss;
            rem_reg <= an;
            ad_reg <= ad;
            tq_reg <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            rem_reg <= ge ? CW'(rem2 - {1'b0, ad_reg}) : CW'(rem2);
            tq_reg <= {tq_reg[T_FRAC_BITS-2:0], ge};
        end
        if (state_reg == ST_LERP)
        begin
            if (cnt_reg < CNTW'(NATTR))
            begin
                dneg1_reg <= attr_d[32];
                dmag_reg <= attr_d[32] ? 33'(-attr_d) : 33'(attr_d);
                abase1_reg <= attr_a[31:0];
            end
            dneg2_reg <= dneg1_reg;
            abase2_reg <= abase1_reg;
            if (cnt_reg >= CNTW'(2))
                res_reg[res_idx] <= lerp_val;
        end
        if (state_reg == ST_OUT && out_free)
        begin
            if (miss_reg)
            begin
                out_hit_reg <= 1'b0;
                out_x_reg <= '0; out_y_reg <= '0; out_z_reg <= '0;
                out_u_reg <= '0; out_v_reg <= '0;
                out_red_reg <= '0; out_green_reg <= '0; out_blue_reg <= '0;
            end
            else
            begin
                out_hit_reg <= 1'b1;
                if (cfg.side == SIDE_LEFT || cfg.side == SIDE_RIGHT)
                begin
                    out_x_reg <= cfg.esx;
                    out_y_reg <= res_reg[0];
                end
                else
                begin
                    out_x_reg <= res_reg[0];
                    out_y_reg <= cfg.esy;
                end
                out_z_reg <= res_reg[1];
                out_u_reg <= res_reg[2];
                out_v_reg <= res_reg[3];
                out_red_reg <= res_reg[4][7:0];
                out_green_reg <= res_reg[5][7:0];
                out_blue_reg <= res_reg[6][7:0];
            end
        end
    end

    assign hit       = out_hit_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_u     = out_u_reg;
    assign out_v     = out_v_reg;
    assign out_red   = out_red_reg;
    assign out_green = out_green_reg;
    assign out_blue  = out_blue_reg;

    a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> cnt_reg < CNTW'(T_FRAC_BITS))
        else $error("divider step count out of range");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_hit_reg |-> out_z_reg == '0 && out_red_reg == '0)
        else $error("miss result carries nonzero fields");

    a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> state_reg == ST_CROSS && cnt_reg == '0)
        else $error("queue request taken without starting cross products");

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for clip_edge_intersect_interp: segment crossing and attribute interpolation.
`timescale 1ns / 100ps

module tb;
    import cei_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic [2:0]  wr_index;
    logic [31:0] wr_data;
    logic        push;
    logic        full;
    logic        is_second;
    logic [31:0] vert_x, vert_y, vert_z, vert_u, vert_v;
    logic [7:0]  vert_red, vert_green, vert_blue;
    logic        empty;
    logic        pop;
    logic        hit;
    logic [31:0] out_x, out_y, out_z, out_u, out_v;
    logic [7:0]  out_red, out_green, out_blue;

    typedef struct packed {
        logic        hit;
        logic [31:0] x, y, z, u, v;
        logic [7:0]  r, g, b;
    } crossing_t;

    typedef struct packed {
        logic        second;
        logic [31:0] x, y, z, u, v;
        logic [7:0]  r, g, b;
    } vertex_t;

    crossing_t   crossings_due[$];
    logic [31:0] edge_sx, edge_sy, edge_ex, edge_ey;
    logic [1:0]  side;
    vertex_t     held;
    int          errors;
    int          mismatches;
    int          send_idle;
    int          take_idle;
    longint      cycles;

    clip_edge_intersect_interp uut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 64'd2_000_000)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [31:0] lerp_at(logic signed [63:0] a, logic signed [63:0] b,
                                            logic [63:0] tq);
        logic signed [63:0] d;
        logic [63:0]        mag;
        logic [63:0]        s;
        logic signed [63:0] r;
        d = b - a;
        mag = d < 0 ? -d : d;
        s = (mag * tq) >> 16;
        r = d < 0 ? a - $signed(s) : a + $signed(s);
        return r[31:0];
    endfunction

    function automatic crossing_t clip_segment(vertex_t vx);
        crossing_t          c;
        logic signed [63:0] e0x, e0y, dx, dy, sx, sy, px, py;
        logic signed [127:0] num, den;
        logic [127:0]       an, ad, rem;
        logic [63:0]        tq;
        c = '0;
        e0x = $signed(edge_sx);
        e0y = $signed(edge_sy);
        dx = $signed(edge_ex) - e0x;
        dy = $signed(edge_ey) - e0y;
        sx = $signed(held.x);
        sy = $signed(held.y);
        px = $signed(vx.x);
        py = $signed(vx.y);
        den = $signed(128'(px - sx)) * $signed(128'(dy)) - $signed(128'(py - sy)) * $signed(128'(dx));
        num = $signed(128'(e0x - sx)) * $signed(128'(dy)) - $signed(128'(e0y - sy)) * $signed(128'(dx));
        if (den == 0 || num == 0 || (den < 0) != (num < 0))
            return c;
        an = num < 0 ? -num : num;
        ad = den < 0 ? -den : den;
        if (an >= ad)
            return c;
        rem = an;
        tq = 0;
        for (int i = 0; i < 16; i++)
        begin
            rem = rem << 1;
            tq = tq << 1;
            if (rem >= ad)
            begin
                rem = rem - ad;
                tq[0] = 1'b1;
            end
        end
        c.hit = 1'b1;
        if (side == SIDE_TOP || side == SIDE_BOTTOM)
        begin
            c.x = lerp_at(sx, px, tq);
            c.y = edge_sy;
        end
        else
        begin
            c.x = edge_sx;
            c.y = lerp_at(sy, py, tq);
        end
        c.z = lerp_at($signed(held.z), $signed(vx.z), tq);
        c.u = lerp_at($signed(held.u), $signed(vx.u), tq);
        c.v = lerp_at($signed(held.v), $signed(vx.v), tq);
        c.r = 8'(lerp_at({56'd0, held.r}, {56'd0, vx.r}, tq));
        c.g = 8'(lerp_at({56'd0, held.g}, {56'd0, vx.g}, tq));
        c.b = 8'(lerp_at({56'd0, held.b}, {56'd0, vx.b}, tq));
        return c;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        case (idx)
            CFG_EDGE_START_X: edge_sx = data;
            CFG_EDGE_START_Y: edge_sy = data;
            CFG_EDGE_END_X:   edge_ex = data;
            CFG_EDGE_END_Y:   edge_ey = data;
            CFG_CLIP_SIDE:    side = data[1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        while (crossings_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic set_edge(logic [31:0] sx, logic [31:0] sy, logic [31:0] ex, logic [31:0] ey,
                            logic [1:0] sd);
        wait_idle();
        write_reg(CFG_EDGE_START_X, sx);
        write_reg(CFG_EDGE_START_Y, sy);
        write_reg(CFG_EDGE_END_X, ex);
        write_reg(CFG_EDGE_END_Y, ey);
        write_reg(CFG_CLIP_SIDE, {30'd0, sd});
    endtask

    task automatic send_vertex(vertex_t vx);
        while ($urandom_range(99) < send_idle)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        is_second <= vx.second;
        vert_x <= vx.x;
        vert_y <= vx.y;
        vert_z <= vx.z;
        vert_u <= vx.u;
        vert_v <= vx.v;
        vert_red <= vx.r;
        vert_green <= vx.g;
        vert_blue <= vx.b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        if (vx.second)
            crossings_due.push_back(clip_segment(vx));
        else
            held = vx;
    endtask

    always @(posedge clk)
    begin
        crossing_t want;
        crossing_t got;
        if (rst_n && pop && !empty)
        begin
            got = {hit, out_x, out_y, out_z, out_u, out_v, out_red, out_green, out_blue};
            if (crossings_due.size() == 0)
            begin
                errors++;
                $display("unexpected request out: %h", got);
            end
            else
            begin
                want = crossings_due.pop_front();
                if (got !== want)
                begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h actual %h", want, got);
                end
            end
        end
        pop <= ($urandom_range(99) >= take_idle);
    end

    function automatic logic [31:0] pick_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) << 16 | 32'($urandom_range(65535));
            default: return 32'($signed($urandom_range(200)) - 100) << 16;
        endcase
    endfunction

    function automatic vertex_t random_vertex(logic second, int mode);
        vertex_t vx;
        vx.second = second;
        vx.x = pick_coord(mode);
        vx.y = pick_coord(mode);
        vx.z = $urandom;
        vx.u = $urandom;
        vx.v = $urandom;
        vx.r = 8'($urandom);
        vx.g = 8'($urandom);
        vx.b = 8'($urandom);
        return vx;
    endfunction

    task automatic test_directed();
        vertex_t vx;
        // close before any hold uses the zero start
        set_edge(32'h0001_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, SIDE_LEFT);
        vx = '{1'b1, 32'h0004_0000, 32'h0000_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 8'hFF, 8'h00, 8'h80};
        send_vertex(vx);
        vx = '{1'b0, 32'hFFFE_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 8'h00, 8'hFF, 8'h01};
        send_vertex(vx);
        vx.second = 1'b1; vx.x = 32'h0003_0000; vx.y = 32'h0002_0000;
        send_vertex(vx);
        vx.x = 32'hFFFE_0000;
        send_vertex(vx);  // parallel: stays left of the edge line
        vx.x = 32'h0001_0000;
        send_vertex(vx);  // ends on the edge: t equals one
        vx.x = 32'h8000_0000; vx.y = 32'h7FFF_FFFF;
        send_vertex(vx);  // moves away: t out of range
        vx.x = 32'h7FFF_FFFF; vx.y = 32'h8000_0000;
        send_vertex(vx);
        set_edge(32'h8000_0000, 32'h0, 32'h7FFF_FFFF, 32'h0, SIDE_TOP);
        vx = '{1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 8'h00, 8'h00, 8'h00};
        send_vertex(vx);
        vx = '{1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'hFF, 8'hFF, 8'hFF};
        send_vertex(vx);
        vx = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h0, 8'h0, 8'h0};
        send_vertex(vx);  // start on the edge: t equals zero
        vx.second = 1'b1; vx.y = 32'h0001_0000;
        send_vertex(vx);
        set_edge(32'h0, 32'h0005_0000, 32'h0001_0000, 32'h0005_0000, SIDE_BOTTOM);
        vx = '{1'b0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 8'h10, 8'h20, 8'h30};
        send_vertex(vx);
        vx = '{1'b1, 32'h0009_0000, 32'h000A_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 8'hF0, 8'h00, 8'h30};
        send_vertex(vx);
        set_edge(32'h0003_0000, 32'h7FFF_FFFF, 32'h0003_0000, 32'h8000_0000, SIDE_RIGHT);
        send_vertex(vx);
        vx.x = 32'hFFFF_0000;
        send_vertex(vx);
        wait_idle();
        write_reg(3'd5, 32'hDEAD_BEEF);
        write_reg(3'd7, 32'h1234_5678);
    endtask

    task automatic test_random(int pairs);
        vertex_t vx;
        int      mode;
        for (int p = 0; p < pairs; p++)
        begin
            if (p % 60 == 0)
                set_edge(pick_coord(p % 120 == 0 ? 0 : 1), pick_coord(1), pick_coord(1),
                         pick_coord(p % 180 == 0 ? 0 : 2), 2'($urandom_range(3)));
            mode = $urandom_range(9) == 0 ? 0 : ($urandom_range(3) == 0 ? 2 : 1);
            if ($urandom_range(9) != 0)
                send_vertex(random_vertex(1'b0, mode));
            send_vertex(random_vertex(1'b1, mode));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        wr_en = 1'b0; wr_index = '0; wr_data = '0;
        push = 1'b0; is_second = 1'b0;
        vert_x = '0; vert_y = '0; vert_z = '0; vert_u = '0; vert_v = '0;
        vert_red = '0; vert_green = '0; vert_blue = '0;
        pop = 1'b0;
        cycles = 0; errors = 0; mismatches = 0;
        edge_sx = '0; edge_sy = '0; edge_ex = '0; edge_ey = '0; side = '0;
        held = '0;
        send_idle = 0; take_idle = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        send_idle = 6; take_idle = 59;
        test_random(330);
        send_idle = 59; take_idle = 6;
        test_random(330);
        send_idle = 0; take_idle = 0;
        test_random(330);
        wait_idle();
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

// ===== filelist.f =====
sv/cei_pkg.sv
sv/cei_front.sv
sv/cei_back.sv
sv/clip_edge_intersect_interp.sv
tb/tb.sv
